/* src/matrix3x3_inverse_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 matrix inverse block
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH

// Check prop in the same cycle as cond.
`define MI3_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Check prop in the cycle after cond.
`define MI3_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* src/mi3_pkg.sv */
// ----------------------------------------------------------------------------
// mi3_pkg
// Widths, payload types and the cofactor index table of the matrix inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned FRAC_BITS  = 16;

  localparam int unsigned PROD_W     = 2 * WORD_BITS;
  localparam int unsigned COF_W      = PROD_W + 1;
  localparam int unsigned PART_W     = PROD_W + 1;
  localparam int unsigned TERM_W     = WORD_BITS + COF_W;
  localparam int unsigned DET_W      = TERM_W + 2;
  localparam int unsigned NUM_W      = COF_W + 2 * FRAC_BITS;
  localparam int unsigned CMP_W      = (NUM_W > DET_W + WORD_BITS) ? NUM_W
                                                                   : DET_W + WORD_BITS;
  localparam int unsigned DIV_STAGES = WORD_BITS + 2;
  localparam int unsigned STAGES     = DIV_STAGES + 6;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic        [WORD_BITS-1:0] uword_t;
  typedef logic signed [COF_W-1:0]     cof_t;
  typedef logic signed [DET_W-1:0]     det_t;
  typedef logic        [DET_W-1:0]     mag_t;
  typedef logic        [NUM_W-1:0]     num_t;
  typedef cof_t        [8:0]           adj_t;
  typedef uword_t      [8:0]           quo_t;

  typedef struct packed {
    word_t a00; word_t a01; word_t a02;
    word_t a10; word_t a11; word_t a12;
    word_t a20; word_t a21; word_t a22;
  } mat_t;

  typedef struct packed {
    word_t r00; word_t r01; word_t r02;
    word_t r10; word_t r11; word_t r12;
    word_t r20; word_t r21; word_t r22;
    logic  invertible;
  } inv_t;

  // adj[k] = e[i0]*e[i1] - e[i2]*e[i3], elements numbered row*3+col
  localparam int unsigned COF_IDX [9][4] = '{
    '{4, 8, 5, 7}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
    '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{2, 3, 0, 5},
    '{3, 7, 6, 4}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  function automatic word_t elem(mat_t m, int unsigned k);
    logic [9*WORD_BITS-1:0] flat;
    flat = m;
    return flat[(8-k)*WORD_BITS +: WORD_BITS];
  endfunction

endpackage

/* src/mi3_cof.sv */
// ----------------------------------------------------------------------------
// mi3_cof
// Two stages: the eighteen element products, then the nine adjugate entries.
// ----------------------------------------------------------------------------
module mi3_cof (
  input  logic          clk,
  input  logic [1:0]    en,
  input  mi3_pkg::mat_t mat_in,
  output mi3_pkg::mat_t mat_out,
  output mi3_pkg::adj_t adj
);

  logic signed [mi3_pkg::PROD_W-1:0] pa [9];
  logic signed [mi3_pkg::PROD_W-1:0] pb [9];
  mi3_pkg::mat_t mat1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mat1 <= mat_in;
      for (int k = 0; k < 9; k++) begin
        pa[k] <= mi3_pkg::elem(mat_in, mi3_pkg::COF_IDX[k][0]) *
                 mi3_pkg::elem(mat_in, mi3_pkg::COF_IDX[k][1]);
        pb[k] <= mi3_pkg::elem(mat_in, mi3_pkg::COF_IDX[k][2]) *
                 mi3_pkg::elem(mat_in, mi3_pkg::COF_IDX[k][3]);
      end
    end
    if (en[1]) begin
      mat_out <= mat1;
      for (int k = 0; k < 9; k++) begin
        adj[k] <= mi3_pkg::COF_W'(pa[k]) - mi3_pkg::COF_W'(pb[k]);
      end
    end
  end

endmodule

/* src/mi3_det.sv */
// ----------------------------------------------------------------------------
// mi3_det
// Three stages: split products of the first column with the first adjugate
// row, recombined terms, and the determinant sum.
// ----------------------------------------------------------------------------
module mi3_det (
  input  logic          clk,
  input  logic [2:0]    en,
  input  mi3_pkg::mat_t mat_in,
  input  mi3_pkg::adj_t adj_in,
  output mi3_pkg::mat_t mat_out,
  output mi3_pkg::adj_t adj_out,
  output mi3_pkg::det_t det
);

  logic signed [mi3_pkg::PART_W-1:0] plo [3];
  logic signed [mi3_pkg::PART_W-1:0] phi [3];
  logic signed [mi3_pkg::TERM_W-1:0] term [3];
  mi3_pkg::mat_t mat1, mat2;
  mi3_pkg::adj_t adj1, adj2;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mat1 <= mat_in;
      adj1 <= adj_in;
      for (int t = 0; t < 3; t++) begin
        plo[t] <= mi3_pkg::elem(mat_in, 3 * t) *
                  $signed({1'b0, adj_in[t][mi3_pkg::WORD_BITS-1:0]});
        phi[t] <= mi3_pkg::elem(mat_in, 3 * t) *
                  $signed(adj_in[t][mi3_pkg::COF_W-1:mi3_pkg::WORD_BITS]);
      end
    end
    if (en[1]) begin
      mat2 <= mat1;
      adj2 <= adj1;
      for (int t = 0; t < 3; t++) begin
        term[t] <= (mi3_pkg::TERM_W'(phi[t]) <<< mi3_pkg::WORD_BITS) +
                   mi3_pkg::TERM_W'(plo[t]);
      end
    end
    if (en[2]) begin
      mat_out <= mat2;
      adj_out <= adj2;
      det     <= mi3_pkg::DET_W'(term[0]) + mi3_pkg::DET_W'(term[1]) +
                 mi3_pkg::DET_W'(term[2]);
    end
  end

endmodule

/* src/mi3_div.sv */
// ----------------------------------------------------------------------------
// mi3_div
// Magnitudes and signs, an overflow check, then one quotient bit per stage
// for nine lanes of restoring division sharing one divisor.
// ----------------------------------------------------------------------------
module mi3_div (
  input  logic                               clk,
  input  logic [mi3_pkg::DIV_STAGES-1:0]     en,
  input  mi3_pkg::mat_t                      mat_in,
  input  mi3_pkg::adj_t                      adj_in,
  input  mi3_pkg::det_t                      det_in,
  output mi3_pkg::mat_t                      mat_out,
  output mi3_pkg::quo_t                      quo_out,
  output logic [8:0]                         neg_out,
  output logic [8:0]                         ovf_out,
  output logic                               zero_out
);

  localparam int unsigned W = mi3_pkg::WORD_BITS;

  logic [mi3_pkg::COF_W-1:0] amag [9];
  mi3_pkg::mag_t             dmag_c;

  mi3_pkg::num_t num0 [9];
  mi3_pkg::mag_t dmag0;
  logic [8:0]    neg0;
  logic          zero0;
  mi3_pkg::mat_t mat0;

  mi3_pkg::mag_t   rem [W+1][9];
  mi3_pkg::uword_t nlo [W+1][9];
  mi3_pkg::uword_t quo [W+1][9];
  mi3_pkg::mag_t   dv  [W+1];
  logic [8:0]      ng  [W+1];
  logic [8:0]      ov  [W+1];
  logic            zr  [W+1];
  mi3_pkg::mat_t   mt  [W+1];

  logic [mi3_pkg::DET_W:0] trial [1:W][9];
  logic                    take  [1:W][9];
  mi3_pkg::mag_t           rnext [1:W][9];

  always_comb begin
    dmag_c = det_in[mi3_pkg::DET_W-1] ? mi3_pkg::mag_t'(-det_in)
                                      : mi3_pkg::mag_t'(det_in);
    for (int k = 0; k < 9; k++) begin
      amag[k] = adj_in[k][mi3_pkg::COF_W-1] ? (~adj_in[k] + 1'b1) : adj_in[k];
    end
  end

  // shift in the next numerator bit, subtract the divisor when it fits
  always_comb begin
    for (int s = 1; s <= W; s++) begin
      for (int k = 0; k < 9; k++) begin
        trial[s][k] = {rem[s-1][k], nlo[s-1][k][W-1]};
        take[s][k]  = trial[s][k] >= {1'b0, dv[s-1]};
        rnext[s][k] = take[s][k] ? mi3_pkg::DET_W'(trial[s][k] - {1'b0, dv[s-1]})
                                 : mi3_pkg::DET_W'(trial[s][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dmag0 <= dmag_c;
      zero0 <= det_in == '0;
      mat0  <= mat_in;
      for (int k = 0; k < 9; k++) begin
        num0[k] <= mi3_pkg::NUM_W'(amag[k]) << (2 * mi3_pkg::FRAC_BITS);
        neg0[k] <= adj_in[k][mi3_pkg::COF_W-1] ^ det_in[mi3_pkg::DET_W-1];
      end
    end
    if (en[1]) begin
      dv[0] <= dmag0;
      ng[0] <= neg0;
      zr[0] <= zero0;
      mt[0] <= mat0;
      for (int k = 0; k < 9; k++) begin
        ov[0][k]  <= mi3_pkg::CMP_W'(num0[k]) >= (mi3_pkg::CMP_W'(dmag0) << W);
        rem[0][k] <= mi3_pkg::DET_W'(num0[k] >> W);
        nlo[0][k] <= num0[k][W-1:0];
        quo[0][k] <= '0;
      end
    end
    for (int s = 1; s <= W; s++) begin
      if (en[s+1]) begin
        dv[s] <= dv[s-1];
        ng[s] <= ng[s-1];
        ov[s] <= ov[s-1];
        zr[s] <= zr[s-1];
        mt[s] <= mt[s-1];
        for (int k = 0; k < 9; k++) begin
          rem[s][k] <= rnext[s][k];
          nlo[s][k] <= nlo[s-1][k] << 1;
          quo[s][k] <= {quo[s-1][k][W-2:0], take[s][k]};
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      quo_out[k] = quo[W][k];
    end
  end

  assign neg_out  = ng[W];
  assign ovf_out  = ov[W];
  assign zero_out = zr[W];
  assign mat_out  = mt[W];

endmodule

/* src/mi3_sat.sv */
// ----------------------------------------------------------------------------
// mi3_sat
// Output register: clamp and sign the quotients, or pass the matrix through
// when the determinant is zero.
// ----------------------------------------------------------------------------
module mi3_sat (
  input  logic          clk,
  input  logic          en,
  input  mi3_pkg::mat_t mat_in,
  input  mi3_pkg::quo_t quo_in,
  input  logic [8:0]    neg_in,
  input  logic [8:0]    ovf_in,
  input  logic          zero_in,
  output mi3_pkg::inv_t inv
);

  localparam int unsigned W = mi3_pkg::WORD_BITS;
  localparam mi3_pkg::uword_t LIM_POS = {1'b0, {(W-1){1'b1}}};
  localparam mi3_pkg::uword_t LIM_NEG = {1'b1, {(W-1){1'b0}}};

  logic [9*W-1:0]  flat;
  mi3_pkg::uword_t lim [9];
  mi3_pkg::uword_t qs  [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      lim[k] = neg_in[k] ? LIM_NEG : LIM_POS;
      qs[k]  = (ovf_in[k] || quo_in[k] > lim[k]) ? lim[k] : quo_in[k];
      flat[(8-k)*W +: W] = zero_in ? mi3_pkg::elem(mat_in, k)
                                   : (neg_in[k] ? (~qs[k] + 1'b1) : qs[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv <= {flat, !zero_in};
    end
  end

endmodule

/* src/matrix3x3_inverse.sv */
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Pipelined inverse of a 3x3 signed Q16.16 matrix through its adjugate.
// ----------------------------------------------------------------------------
// One matrix enters per clock while mat_stall is low; the divider
// resolves one quotient bit per stage for all nine entries at once. The
// front end takes two stages for the adjugate, three for the determinant,
// and two for magnitudes and the overflow check; one output register holds
// the result. Each entry is adj * 2^(2*FRAC_BITS) / det, truncated toward
// zero and clamped to the signed word range. A zero determinant returns the
// input matrix unchanged with invertible low. Every stage carries a valid
// bit and advances when it is empty or the stage after it advances, so a
// stall on the result side fills bubbles first and only holds the input
// once the whole pipeline is full.
// ----------------------------------------------------------------------------
`include "matrix3x3_inverse_assert.svh"

module matrix3x3_inverse (
  input  logic          clk,
  input  logic          rst,
  input  logic          mat_valid,
  output logic          mat_stall,
  input  mi3_pkg::mat_t mat,
  output logic          inv_valid,
  input  logic          inv_stall,
  output mi3_pkg::inv_t inv
);

  localparam int unsigned N = mi3_pkg::STAGES;
  localparam int unsigned D = mi3_pkg::DIV_STAGES;

  logic [N-1:0] vld, vld_next, en;

  mi3_pkg::mat_t mat_c, mat_d, mat_q;
  mi3_pkg::adj_t adj_c, adj_d;
  mi3_pkg::det_t det;
  mi3_pkg::quo_t quo;
  logic [8:0]    neg, ovf;
  logic          zero;

  // Advance a stage when any stage at or above it is empty, or the result
  // transfer is not held off.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      en[i] = !inv_stall || (((~vld) >> i) != '0);
    end
    vld_next = (en & {vld[N-2:0], mat_valid}) | (~en & vld);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign mat_stall = !en[0];
  assign inv_valid = vld[N-1];

  mi3_cof u_cof (
    .clk     (clk),
    .en      (en[1:0]),
    .mat_in  (mat),
    .mat_out (mat_c),
    .adj     (adj_c)
  );

  mi3_det u_det (
    .clk     (clk),
    .en      (en[4:2]),
    .mat_in  (mat_c),
    .adj_in  (adj_c),
    .mat_out (mat_d),
    .adj_out (adj_d),
    .det     (det)
  );

  mi3_div u_div (
    .clk      (clk),
    .en       (en[D+4:5]),
    .mat_in   (mat_d),
    .adj_in   (adj_d),
    .det_in   (det),
    .mat_out  (mat_q),
    .quo_out  (quo),
    .neg_out  (neg),
    .ovf_out  (ovf),
    .zero_out (zero)
  );

  mi3_sat u_sat (
    .clk     (clk),
    .en      (en[N-1]),
    .mat_in  (mat_q),
    .quo_in  (quo),
    .neg_in  (neg),
    .ovf_in  (ovf),
    .zero_in (zero),
    .inv     (inv)
  );

  // input holds only when every stage is occupied
  `MI3_ASSERT_NOW(a_stall_full, mat_stall, vld == '1, "input stalled with a free stage")
  // a held input means nothing moved in the pipeline
  `MI3_ASSERT_NEXT(a_stall_frozen, mat_stall, $stable(vld), "pipeline moved while full")
  // an accepted matrix occupies the first stage
  `MI3_ASSERT_NEXT(a_enter, mat_valid && !mat_stall, vld[0], "accepted matrix lost")
  // a taken result with an empty stage behind it leaves the output empty
  `MI3_ASSERT_NEXT(a_drain, inv_valid && !inv_stall && !vld[N-2], !inv_valid, "result repeated")

endmodule

/* sim/tb_matrix3x3_inverse.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix3x3_inverse
// Self-checking bench for the pipelined 3x3 matrix inverse. A queue-fed
// driver pushes directed and random matrices; a monitor compares every
// inverse transfer against a wide-integer adjugate/determinant predictor.
// ----------------------------------------------------------------------------
module tb_matrix3x3_inverse;

  localparam int unsigned NUM_RANDOM = 700;
  localparam int unsigned DRAIN_CYC  = mi3_pkg::STAGES + 20;
  localparam longint      CYCLE_LIMIT = 400000;

  typedef logic signed [255:0] wide_t;

  logic          clk;
  logic          rst;
  logic          mat_valid;
  logic          mat_stall;
  mi3_pkg::mat_t mat;
  logic          inv_valid;
  logic          inv_stall;
  mi3_pkg::inv_t inv;

  mi3_pkg::mat_t pending_mats[$];
  mi3_pkg::inv_t expected_invs[$];
  bit            failed;
  bit            stim_done;
  bit            quiet_stretch;
  longint        cycle_count;

  matrix3x3_inverse u_top (
    .clk       (clk),
    .rst       (rst),
    .mat_valid (mat_valid),
    .mat_stall (mat_stall),
    .mat       (mat),
    .inv_valid (inv_valid),
    .inv_stall (inv_stall),
    .inv       (inv)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Truncated quotient of adj*2^(2F)/det, clamped to the signed word range.
  function automatic mi3_pkg::word_t scaled_entry(wide_t adj, wide_t det);
    wide_t num;
    wide_t quo;
    wide_t hi;
    wide_t lo;
    num = adj <<< (2 * mi3_pkg::FRAC_BITS);
    quo = num / det;  // SV signed division truncates toward zero
    hi  = (wide_t'(1) <<< (mi3_pkg::WORD_BITS - 1)) - 1;
    lo  = -(wide_t'(1) <<< (mi3_pkg::WORD_BITS - 1));
    if (quo > hi) quo = hi;
    if (quo < lo) quo = lo;
    return mi3_pkg::word_t'(quo[mi3_pkg::WORD_BITS-1:0]);
  endfunction

  function automatic mi3_pkg::inv_t invert_matrix(mi3_pkg::mat_t m);
    wide_t          e[9];
    wide_t          adj[9];
    wide_t          det;
    mi3_pkg::word_t w[9];
    mi3_pkg::inv_t  r;
    w = '{m.a00, m.a01, m.a02, m.a10, m.a11, m.a12, m.a20, m.a21, m.a22};
    for (int k = 0; k < 9; k++) e[k] = wide_t'(w[k]);
    adj[0] = e[4]*e[8] - e[5]*e[7];
    adj[1] = e[7]*e[2] - e[1]*e[8];
    adj[2] = e[1]*e[5] - e[4]*e[2];
    adj[3] = e[6]*e[5] - e[3]*e[8];
    adj[4] = e[0]*e[8] - e[6]*e[2];
    adj[5] = e[2]*e[3] - e[0]*e[5];
    adj[6] = e[3]*e[7] - e[6]*e[4];
    adj[7] = e[1]*e[6] - e[0]*e[7];
    adj[8] = e[0]*e[4] - e[1]*e[3];
    det = e[0]*adj[0] + e[3]*adj[1] + e[6]*adj[2];
    if (det == 0) begin
      for (int k = 0; k < 9; k++)
        r[1 + (8-k)*mi3_pkg::WORD_BITS +: mi3_pkg::WORD_BITS] = w[k];
      r.invertible = 1'b0;
    end else begin
      for (int k = 0; k < 9; k++)
        r[1 + (8-k)*mi3_pkg::WORD_BITS +: mi3_pkg::WORD_BITS] = scaled_entry(adj[k], det);
      r.invertible = 1'b1;
    end
    return r;
  endfunction

  function automatic mi3_pkg::word_t rand_elem();
    case ($urandom_range(0, 7))
      0: return mi3_pkg::word_t'($urandom);
      1: return 32'sh7FFFFFFF;
      2: return 32'sh80000000;
      3: return mi3_pkg::word_t'(int'($urandom_range(0, 8)) - 4) <<< mi3_pkg::FRAC_BITS;
      4: return mi3_pkg::word_t'(int'($urandom_range(0, 64)) - 32);
      default: return mi3_pkg::word_t'(int'($urandom_range(0, 32'h00080000))
                                       - 32'sh00040000);
    endcase
  endfunction

  function automatic mi3_pkg::mat_t diag(mi3_pkg::word_t d0, mi3_pkg::word_t d1,
                                         mi3_pkg::word_t d2);
    mi3_pkg::mat_t m;
    m = '0;
    m.a00 = d0; m.a11 = d1; m.a22 = d2;
    return m;
  endfunction

  function automatic mi3_pkg::mat_t rand_matrix();
    mi3_pkg::mat_t m;
    m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
         rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    // Force a singular matrix now and then: duplicate one row.
    if ($urandom_range(0, 9) == 0) begin
      m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
    end
    return m;
  endfunction

  initial begin
    mi3_pkg::mat_t m;
    localparam mi3_pkg::word_t ONE = 32'sh00010000;
    // Directed: identity, scaled diagonals, extremes, singular cases.
    pending_mats.push_back(diag(ONE, ONE, ONE));
    pending_mats.push_back(diag(ONE <<< 1, -ONE, 32'sh00008000));
    pending_mats.push_back(diag(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
    pending_mats.push_back(diag(32'sh80000000, 32'sh80000000, 32'sh80000000));
    pending_mats.push_back(diag(32'sh00000001, 32'sh00000001, 32'sh00000001));
    pending_mats.push_back(diag(32'sh00000001, -32'sh00000001, 32'sh7FFFFFFF));
    pending_mats.push_back('0);
    pending_mats.push_back('1);
    pending_mats.push_back({9{32'sh7FFFFFFF}});
    pending_mats.push_back({9{32'sh80000000}});
    m = diag(ONE, ONE, ONE); m.a01 = 32'sh80000000; m.a12 = 32'sh7FFFFFFF;
    pending_mats.push_back(m);
    m = {32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
         32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000};
    pending_mats.push_back(m);
    m = {ONE, ONE<<<1, ONE*3, ONE*4, ONE*5, ONE*6, ONE*7, ONE*8, ONE*10};
    pending_mats.push_back(m);
    m = {ONE, ONE<<<1, ONE*3, ONE*4, ONE*5, ONE*6, ONE*7, ONE*8, ONE*9};
    pending_mats.push_back(m);  // singular, det exactly zero
    m = {32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F, 32'shF0F0F0F0, 32'sh33333333,
         32'shCCCCCCCC, 32'sh12345678, 32'shEDCBA987, 32'sh00FF00FF};
    pending_mats.push_back(m);
    for (int i = 0; i < NUM_RANDOM; i++) pending_mats.push_back(rand_matrix());
  end

  // Driver: hold the payload while stalled; advance on each transfer.
  always @(posedge clk) begin
    if (rst) begin
      mat_valid <= 1'b0;
      mat <= '0;
    end else begin
      bit accepted;
      bit go;
      accepted = mat_valid && !mat_stall;
      if (accepted) expected_invs.push_back(invert_matrix(mat));
      if (!mat_valid || accepted) begin
        if (accepted && pending_mats.size() == 0) stim_done <= 1'b1;
        // Pause once mid-run until the pipeline drains completely.
        go = pending_mats.size() != 0 && (quiet_stretch || $urandom_range(0, 99) >= 19)
             && !(expected_invs.size() != 0 && pending_mats.size() == NUM_RANDOM / 2);
        if (go) begin
          mat <= pending_mats.pop_front();
          mat_valid <= 1'b1;
        end else begin
          mat_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each inverse transfer with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      inv_stall <= 1'b0;
    end else begin
      if (inv_valid && !inv_stall) begin
        if (expected_invs.size() == 0) begin
          $display("%0t: unexpected inverse transfer %h", $realtime, inv);
          failed = 1'b1;
        end else begin
          mi3_pkg::inv_t exp_inv;
          exp_inv = expected_invs.pop_front();
          if (exp_inv !== inv) begin
            $display("%0t: mismatch expected %h actual %h", $realtime, exp_inv, inv);
            failed = 1'b1;
          end
        end
      end
      inv_stall <= !quiet_stretch && ($urandom_range(0, 99) < 19);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    quiet_stretch <= (cycle_count > 300 && cycle_count < 600);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    failed = 1'b0;
    stim_done = 1'b0;
    quiet_stretch = 1'b0;
    cycle_count = 0;
    mat_valid = 1'b0;
    mat = '0;
    inv_stall = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && expected_invs.size() == 0 && !mat_valid);
    repeat (DRAIN_CYC) @(posedge clk);
    if (!failed && expected_invs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/mi3_pkg.sv
src/mi3_cof.sv
src/mi3_det.sv
src/mi3_div.sv
src/mi3_sat.sv
src/matrix3x3_inverse.sv
sim/tb_matrix3x3_inverse.sv
